// ===== hw/rtl/adcvm_pkg.sv =====
// ----------------------------------------------------------------------------
// adcvm_pkg
// Shared widths, reset values, register indexes and the segment encoder for
// the ADC voltmeter with seven-segment display.
// ----------------------------------------------------------------------------
package adcvm_pkg;

    localparam int SAMPLE_BITS = 12;
    localparam int CNT_W       = 7;
    localparam int FS_W        = 14;
    localparam int MV_W        = 14;
    localparam int PROD_W      = SAMPLE_BITS + FS_W;
    localparam int WORD_W      = 16;
    localparam int SEG_W       = 8;
    localparam int DIGIT_W     = 4;
    localparam int DATA_W      = 32;
    localparam int ADDR_W      = 3;

    localparam int QUEUE_DEPTH = 4;
    localparam int QUEUE_AW    = $clog2(QUEUE_DEPTH);

    localparam logic [CNT_W-1:0] SPU_RESET = 7'd100;
    localparam logic [FS_W-1:0]  FS_RESET  = 14'd3000;
    localparam logic [MV_W-1:0]  MV_MAX    = 14'd9999;

    // Thousands byte with the decimal point lit (common anode: lit = 0)
    localparam logic [SEG_W-1:0] SEG_POINT_MASK = 8'h7F;
    localparam logic [SEG_W-1:0] SEG_BLANK      = 8'hFF;

    // Register index, taken from paddr[2]
    localparam logic REG_SAMPLES_PER_UPDATE = 1'b0;
    localparam logic REG_FULL_SCALE_MV      = 1'b1;

    typedef struct packed {
        logic full;
        logic empty;
    } t_queue_status;

    function automatic logic [SEG_W-1:0] seg_encode(input logic [DIGIT_W-1:0] digit);
        logic [SEG_W-1:0] seg;
        case (digit)
            4'd0:    seg = 8'hC0;
            4'd1:    seg = 8'hF9;
            4'd2:    seg = 8'hA4;
            4'd3:    seg = 8'hB0;
            4'd4:    seg = 8'h99;
            4'd5:    seg = 8'h92;
            4'd6:    seg = 8'h82;
            4'd7:    seg = 8'hF8;
            4'd8:    seg = 8'h80;
            4'd9:    seg = 8'h90;
            default: seg = SEG_BLANK;
        endcase
        return seg;
    endfunction

endpackage

// ===== hw/rtl/adc_voltmeter_seven_segment.sv =====
// ----------------------------------------------------------------------------
// adc_voltmeter_seven_segment
// Takes one ADC sample per transaction and accepts a new sample every clock
// cycle while the four-entry update queue has room. Each sample updates the
// running average in the same cycle; every samples_per_update samples the
// average is queued and runs through a five-stage display pipeline (scale
// multiply, saturate, thousands digit, hundreds digit, tens and ones with
// segment encoding), passing the queue and then s1 to s5, one result per
// cycle sustained while the output is not held; when held, the pipeline
// stalls and the queue absorbs up to four further updates before intake
// stops. Registers: samples_per_update at 0x0, full_scale_mv at 0x4.
// ----------------------------------------------------------------------------
module adc_voltmeter_seven_segment (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    // sample channel
    input  logic                               i_valid,
    output logic                               o_ready,
    input  logic [adcvm_pkg::SAMPLE_BITS-1:0]  i_adc_sample,
    // display channel
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [adcvm_pkg::WORD_W-1:0]       o_upper_word,
    output logic [adcvm_pkg::WORD_W-1:0]       o_lower_word,
    output logic [adcvm_pkg::MV_W-1:0]         o_millivolts,
    // register port
    input  logic                               psel,
    input  logic                               penable,
    input  logic                               pwrite,
    input  logic [adcvm_pkg::ADDR_W-1:0]       paddr,
    input  logic [adcvm_pkg::DATA_W-1:0]       pwdata,
    output logic [adcvm_pkg::DATA_W-1:0]       prdata,
    output logic                               pready
);

    logic [adcvm_pkg::CNT_W-1:0]       r_samples_per_update;
    logic [adcvm_pkg::FS_W-1:0]        r_full_scale_mv;
    logic                              w_cfg_wr;
    adcvm_pkg::t_queue_status          w_q_status;
    logic                              w_push;
    logic [adcvm_pkg::SAMPLE_BITS-1:0] w_push_avg;
    logic                              w_pop;
    logic [adcvm_pkg::SAMPLE_BITS-1:0] w_q_data;

    assign pready   = 1'b1;
    assign w_cfg_wr = psel && penable && pwrite && pready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_samples_per_update <= adcvm_pkg::SPU_RESET;
            r_full_scale_mv      <= adcvm_pkg::FS_RESET;
        end else if (w_cfg_wr) begin
            case (paddr[2])
                adcvm_pkg::REG_SAMPLES_PER_UPDATE:
                    r_samples_per_update <= pwdata[adcvm_pkg::CNT_W-1:0];
                adcvm_pkg::REG_FULL_SCALE_MV:
                    r_full_scale_mv <= pwdata[adcvm_pkg::FS_W-1:0];
                default: ;
            endcase
        end
    end

    always_comb begin
        case (paddr[2])
            adcvm_pkg::REG_SAMPLES_PER_UPDATE:
                prdata = adcvm_pkg::DATA_W'(r_samples_per_update);
            adcvm_pkg::REG_FULL_SCALE_MV:
                prdata = adcvm_pkg::DATA_W'(r_full_scale_mv);
            default:
                prdata = '0;
        endcase
    end

    adcvm_front u_front (
        .i_clk                (i_clk),
        .i_rst_n              (i_rst_n),
        .i_valid              (i_valid),
        .i_adc_sample         (i_adc_sample),
        .o_ready              (o_ready),
        .i_samples_per_update (r_samples_per_update),
        .i_queue_status       (w_q_status),
        .o_push               (w_push),
        .o_push_avg           (w_push_avg)
    );

    adcvm_queue u_queue (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_push      (w_push),
        .i_push_data (w_push_avg),
        .i_pop       (w_pop),
        .o_rd_data   (w_q_data),
        .o_status    (w_q_status)
    );

    adcvm_back u_back (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_full_scale_mv (r_full_scale_mv),
        .i_queue_status  (w_q_status),
        .i_avg           (w_q_data),
        .o_pop           (w_pop),
        .o_valid         (o_valid),
        .i_ready         (i_ready),
        .o_upper_word    (o_upper_word),
        .o_lower_word    (o_lower_word),
        .o_millivolts    (o_millivolts)
    );

    // The queue must never be pushed while full: that would drop an update
    a_no_overflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_push && w_q_status.full))
        else $error("update queue overflow");

    // A popped entry must exist
    a_no_underflow: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !(w_pop && w_q_status.empty))
        else $error("update queue underflow");

    // Displayed value stays within four digits
    a_mv_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> (o_millivolts <= adcvm_pkg::MV_MAX))
        else $error("millivolts out of range");

    // The decimal point is lit on every displayed frame
    a_point_lit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> !o_upper_word[15])
        else $error("decimal point not lit");

endmodule

// ===== hw/rtl/adcvm_front.sv =====
// ----------------------------------------------------------------------------
// adcvm_front
// Sample intake: folds each sample into the running average, counts samples
// and pushes a snapshot of the average when a display update is due.
// ----------------------------------------------------------------------------
module adcvm_front (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_valid,
    input  logic [adcvm_pkg::SAMPLE_BITS-1:0]  i_adc_sample,
    output logic                               o_ready,
    input  logic [adcvm_pkg::CNT_W-1:0]        i_samples_per_update,
    input  adcvm_pkg::t_queue_status           i_queue_status,
    output logic                               o_push,
    output logic [adcvm_pkg::SAMPLE_BITS-1:0]  o_push_avg
);

    logic [adcvm_pkg::SAMPLE_BITS-1:0] r_avg;
    logic [adcvm_pkg::SAMPLE_BITS-1:0] n_avg;
    logic [adcvm_pkg::CNT_W-1:0]       r_count;
    logic [adcvm_pkg::CNT_W-1:0]       n_count;
    logic [adcvm_pkg::CNT_W-1:0]       w_count_inc;
    logic [adcvm_pkg::SAMPLE_BITS:0]   w_sum;
    logic                              w_accept;
    logic                              w_due;

    assign o_ready  = !i_queue_status.full;
    assign w_accept = i_valid && o_ready;

    assign w_sum       = {1'b0, r_avg} + {1'b0, i_adc_sample};
    assign w_count_inc = r_count + 1'b1;
    // Compare with >= so a lowered interval (or zero) fires on the next sample
    assign w_due       = (w_count_inc >= i_samples_per_update);

    always_comb begin
        n_avg   = r_avg;
        n_count = r_count;
        if (w_accept) begin
            n_avg   = w_sum[adcvm_pkg::SAMPLE_BITS:1];
            n_count = w_due ? '0 : w_count_inc;
        end
    end

    assign o_push     = w_accept && w_due;
    assign o_push_avg = n_avg;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_avg   <= '0;
            r_count <= '0;
        end else begin
            r_avg   <= n_avg;
            r_count <= n_count;
        end
    end

endmodule

// ===== hw/rtl/adcvm_queue.sv =====
// ----------------------------------------------------------------------------
// adcvm_queue
// Short FIFO of average snapshots between sample intake and the display
// pipeline.
// ----------------------------------------------------------------------------
module adcvm_queue (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic                               i_push,
    input  logic [adcvm_pkg::SAMPLE_BITS-1:0]  i_push_data,
    input  logic                               i_pop,
    output logic [adcvm_pkg::SAMPLE_BITS-1:0]  o_rd_data,
    output adcvm_pkg::t_queue_status           o_status
);

    logic [adcvm_pkg::SAMPLE_BITS-1:0] r_mem [adcvm_pkg::QUEUE_DEPTH];
    logic [adcvm_pkg::QUEUE_AW-1:0]    r_wr_ptr;
    logic [adcvm_pkg::QUEUE_AW-1:0]    r_rd_ptr;
    logic [adcvm_pkg::QUEUE_AW:0]      r_fill;
    logic                              w_do_push;
    logic                              w_do_pop;

    assign o_status.full  = (r_fill == (adcvm_pkg::QUEUE_AW + 1)'(adcvm_pkg::QUEUE_DEPTH));
    assign o_status.empty = (r_fill == '0);
    assign o_rd_data      = r_mem[r_rd_ptr];

    assign w_do_push = i_push && !o_status.full;
    assign w_do_pop  = i_pop && !o_status.empty;

    always_ff @(posedge i_clk) begin
        if (w_do_push) begin
            r_mem[r_wr_ptr] <= i_push_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_fill   <= '0;
        end else begin
            if (w_do_push) begin
                r_wr_ptr <= r_wr_ptr + 1'b1;
            end
            if (w_do_pop) begin
                r_rd_ptr <= r_rd_ptr + 1'b1;
            end
            case ({w_do_push, w_do_pop})
                2'b10:   r_fill <= r_fill + 1'b1;
                2'b01:   r_fill <= r_fill - 1'b1;
                default: r_fill <= r_fill;
            endcase
        end
    end

endmodule

// ===== hw/rtl/adcvm_back.sv =====
// ----------------------------------------------------------------------------
// adcvm_back
// Display pipeline: scale the average to millivolts, saturate, split into
// decimal digits and encode the segment words. Five stages, stalled as a
// whole when the output register is held.
// ----------------------------------------------------------------------------
module adcvm_back (
    input  logic                               i_clk,
    input  logic                               i_rst_n,
    input  logic [adcvm_pkg::FS_W-1:0]         i_full_scale_mv,
    input  adcvm_pkg::t_queue_status           i_queue_status,
    input  logic [adcvm_pkg::SAMPLE_BITS-1:0]  i_avg,
    output logic                               o_pop,
    output logic                               o_valid,
    input  logic                               i_ready,
    output logic [adcvm_pkg::WORD_W-1:0]       o_upper_word,
    output logic [adcvm_pkg::WORD_W-1:0]       o_lower_word,
    output logic [adcvm_pkg::MV_W-1:0]         o_millivolts
);

    logic                           w_adv;

    // Stage 1: product
    logic                           r_s1_vld;
    logic [adcvm_pkg::PROD_W-1:0]   r_s1_prod;
    // Stage 2: saturated millivolts
    logic                           r_s2_vld;
    logic [adcvm_pkg::MV_W-1:0]     r_s2_mv;
    logic [adcvm_pkg::MV_W-1:0]     w_scaled;
    // Stage 3: thousands digit
    logic                           r_s3_vld;
    logic [adcvm_pkg::MV_W-1:0]     r_s3_mv;
    logic [adcvm_pkg::DIGIT_W-1:0]  r_s3_d1;
    logic [9:0]                     r_s3_rem;
    logic [27:0]                    w_q1000;
    logic [adcvm_pkg::DIGIT_W-1:0]  w_d1;
    logic [adcvm_pkg::MV_W-1:0]     w_rem1;
    // Stage 4: hundreds digit
    logic                           r_s4_vld;
    logic [adcvm_pkg::MV_W-1:0]     r_s4_mv;
    logic [adcvm_pkg::DIGIT_W-1:0]  r_s4_d1;
    logic [adcvm_pkg::DIGIT_W-1:0]  r_s4_d2;
    logic [6:0]                     r_s4_rem;
    logic [15:0]                    w_q100;
    logic [adcvm_pkg::DIGIT_W-1:0]  w_d2;
    logic [9:0]                     w_rem2;
    // Stage 5: tens and ones, encode
    logic                           r_s5_vld;
    logic [13:0]                    w_q10;
    logic [adcvm_pkg::DIGIT_W-1:0]  w_d3;
    logic [6:0]                     w_rem3;
    logic [adcvm_pkg::SEG_W-1:0]    w_seg1;

    assign w_adv = !r_s5_vld || i_ready;
    assign o_pop = w_adv && !i_queue_status.empty;

    assign w_scaled = r_s1_prod[adcvm_pkg::PROD_W-1:adcvm_pkg::SAMPLE_BITS];

    // mv / 1000 as (mv * 8389) >> 23, exact for mv <= 9999
    assign w_q1000 = 28'(r_s2_mv) * 28'd8389;
    assign w_d1    = w_q1000[26:23];
    assign w_rem1  = r_s2_mv - 14'(w_d1) * 14'd1000;

    // rem / 100 as (rem * 41) >> 12, exact for rem < 1000
    assign w_q100 = 16'(r_s3_rem) * 16'd41;
    assign w_d2   = w_q100[15:12];
    assign w_rem2 = r_s3_rem - 10'(w_d2) * 10'd100;

    // rem / 10 as (rem * 103) >> 10, exact for rem < 100
    assign w_q10  = 14'(r_s4_rem) * 14'd103;
    assign w_d3   = w_q10[13:10];
    assign w_rem3 = r_s4_rem - 7'(w_d3) * 7'd10;

    assign w_seg1 = adcvm_pkg::seg_encode(r_s4_d1) & adcvm_pkg::SEG_POINT_MASK;

    always_ff @(posedge i_clk) begin
        if (w_adv) begin
            r_s1_prod <= adcvm_pkg::PROD_W'(i_avg) * adcvm_pkg::PROD_W'(i_full_scale_mv);
            r_s2_mv   <= (w_scaled > adcvm_pkg::MV_MAX) ? adcvm_pkg::MV_MAX : w_scaled;
            r_s3_mv   <= r_s2_mv;
            r_s3_d1   <= w_d1;
            r_s3_rem  <= w_rem1[9:0];
            r_s4_mv   <= r_s3_mv;
            r_s4_d1   <= r_s3_d1;
            r_s4_d2   <= w_d2;
            r_s4_rem  <= w_rem2[6:0];
            o_millivolts <= r_s4_mv;
            o_upper_word <= {w_seg1, adcvm_pkg::seg_encode(r_s4_d2)};
            o_lower_word <= {adcvm_pkg::seg_encode(w_d3),
                             adcvm_pkg::seg_encode(w_rem3[adcvm_pkg::DIGIT_W-1:0])};
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_s1_vld <= 1'b0;
            r_s2_vld <= 1'b0;
            r_s3_vld <= 1'b0;
            r_s4_vld <= 1'b0;
            r_s5_vld <= 1'b0;
        end else if (w_adv) begin
            r_s1_vld <= !i_queue_status.empty;
            r_s2_vld <= r_s1_vld;
            r_s3_vld <= r_s2_vld;
            r_s4_vld <= r_s3_vld;
            r_s5_vld <= r_s4_vld;
        end
    end

    assign o_valid = r_s5_vld;

endmodule

// ===== tb/tb_adc_voltmeter_seven_segment.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// tb_adc_voltmeter_seven_segment
// Self-checking bench for the ADC voltmeter display block. Streams converter
// samples in under random gaps and output stalls, reprograms the update
// interval and full scale between phases through the register port, and
// compares every display transaction field by field against an in-bench
// model of the running average, millivolt scaling and segment encoding.
// ----------------------------------------------------------------------------
module tb_adc_voltmeter_seven_segment;

    localparam int CLK_HALF     = 4;
    localparam int RESET_CYCLES = 11;
    localparam int SETTLE       = 8;        // pipeline depth plus margin
    localparam int SAMPLE_ITEMS = 1400;
    localparam int CYCLE_LIMIT  = 400000;

    typedef struct packed {
        logic [adcvm_pkg::WORD_W-1:0] upper;
        logic [adcvm_pkg::WORD_W-1:0] lower;
        logic [adcvm_pkg::MV_W-1:0]   mv;
    } t_disp;

    typedef enum logic {ROW_SAMPLE, ROW_WRITE} t_row_kind;

    typedef struct {
        t_row_kind   kind;
        logic        reg_idx;
        logic [31:0] value;
        bit          typed;
        t_disp       want;
    } t_dir_step;

    localparam logic [adcvm_pkg::SEG_W-1:0] SEG_TABLE [10] = '{
        8'hC0, 8'hF9, 8'hA4, 8'hB0, 8'h99, 8'h92, 8'h82, 8'hF8, 8'h80, 8'h90
    };

    // 0.000 and 9.999 as the display shows them
    localparam t_disp DISP_ZERO = '{upper: 16'h40C0, lower: 16'hC0C0, mv: 14'd0};
    localparam t_disp DISP_SAT  = '{upper: 16'h1090, lower: 16'h9090, mv: 14'd9999};

    logic                              i_clk = 1'b0;
    logic                              i_rst_n;
    logic                              i_valid;
    logic                              o_ready;
    logic [adcvm_pkg::SAMPLE_BITS-1:0] i_adc_sample;
    logic                              o_valid;
    logic                              i_ready;
    logic [adcvm_pkg::WORD_W-1:0]      o_upper_word;
    logic [adcvm_pkg::WORD_W-1:0]      o_lower_word;
    logic [adcvm_pkg::MV_W-1:0]        o_millivolts;
    logic                              psel;
    logic                              penable;
    logic                              pwrite;
    logic [adcvm_pkg::ADDR_W-1:0]      paddr;
    logic [adcvm_pkg::DATA_W-1:0]      pwdata;
    logic [adcvm_pkg::DATA_W-1:0]      prdata;
    logic                              pready;

    // model state and registers
    logic [adcvm_pkg::SAMPLE_BITS-1:0] avg_q;
    logic [adcvm_pkg::CNT_W-1:0]       count_q;
    logic [adcvm_pkg::CNT_W-1:0]       spu_q;
    logic [adcvm_pkg::FS_W-1:0]        fs_q;

    t_disp       pending_displays[$];
    t_dir_step   plan[$];
    int          mismatches  = 0;
    int          items_sent  = 0;
    int          cycle_count = 0;
    bit          tx_gapless  = 1'b0;
    bit          rx_gapless  = 1'b0;

    adc_voltmeter_seven_segment u_dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_ready      (o_ready),
        .i_adc_sample (i_adc_sample),
        .o_valid      (o_valid),
        .i_ready      (i_ready),
        .o_upper_word (o_upper_word),
        .o_lower_word (o_lower_word),
        .o_millivolts (o_millivolts),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready)
    );

    always begin
        #CLK_HALF i_clk = 1'b1;
        #CLK_HALF i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("Regression FAIL");
            $finish;
        end
    end

    task automatic report_mismatch(input string msg);
        $display("[%0t] MISMATCH %s", $realtime, msg);
        mismatches++;
    endtask

    // Fold one sample into the average; fire a display update on interval.
    function automatic void fold_sample(input logic [adcvm_pkg::SAMPLE_BITS-1:0] smp,
                                        output bit fired, output t_disp d);
        logic [adcvm_pkg::SAMPLE_BITS:0] sum;
        logic [adcvm_pkg::PROD_W-1:0]    prod;
        logic [adcvm_pkg::PROD_W-1:0]    scaled;
        logic [adcvm_pkg::MV_W-1:0]      mv;
        int                              d1, d2, d3, d4;
        sum     = {1'b0, avg_q} + {1'b0, smp};
        avg_q   = sum[adcvm_pkg::SAMPLE_BITS:1];
        count_q = count_q + 1'b1;
        fired   = (count_q >= spu_q);
        d       = '0;
        if (fired) begin
            count_q = '0;
            prod    = adcvm_pkg::PROD_W'(avg_q) * adcvm_pkg::PROD_W'(fs_q);
            scaled  = prod >> adcvm_pkg::SAMPLE_BITS;
            mv      = (scaled > adcvm_pkg::PROD_W'(adcvm_pkg::MV_MAX)) ?
                      adcvm_pkg::MV_MAX : scaled[adcvm_pkg::MV_W-1:0];
            d1      = mv / 1000;
            d2      = (mv / 100) % 10;
            d3      = (mv / 10) % 10;
            d4      = mv % 10;
            d.upper = {SEG_TABLE[d1] & adcvm_pkg::SEG_POINT_MASK, SEG_TABLE[d2]};
            d.lower = {SEG_TABLE[d3], SEG_TABLE[d4]};
            d.mv    = mv;
        end
    endfunction

    function automatic t_dir_step mk_row(t_row_kind kind, logic reg_idx,
                                         logic [31:0] value, bit typed, t_disp want);
        t_dir_step r;
        r.kind    = kind;
        r.reg_idx = reg_idx;
        r.value   = value;
        r.typed   = typed;
        r.want    = want;
        return r;
    endfunction

    // Hold off new samples until every queued update has come out.
    task automatic drain_outputs();
        i_valid <= 1'b0;
        @(posedge i_clk);
        while (pending_displays.size() != 0) @(posedge i_clk);
        repeat (SETTLE) @(posedge i_clk);
    endtask

    task automatic write_reg(input logic reg_idx, input logic [31:0] value);
        drain_outputs();
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {reg_idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (reg_idx == adcvm_pkg::REG_SAMPLES_PER_UPDATE) begin
            spu_q = value[adcvm_pkg::CNT_W-1:0];
        end else begin
            fs_q = value[adcvm_pkg::FS_W-1:0];
        end
    endtask

    task automatic send_sample(input logic [adcvm_pkg::SAMPLE_BITS-1:0] smp, input bit typed,
                               input t_disp want);
        int    gap;
        bit    fired;
        t_disp d;
        gap = tx_gapless ? 0 : $urandom_range(0, 4);
        repeat (gap) begin
            i_valid      <= 1'b0;
            i_adc_sample <= adcvm_pkg::SAMPLE_BITS'($urandom_range(0, 4095));
            @(posedge i_clk);
        end
        i_valid      <= 1'b1;
        i_adc_sample <= smp;
        do @(posedge i_clk); while (!o_ready);
        fold_sample(smp, fired, d);
        if (fired) pending_displays.push_back(typed ? want : d);
        items_sent++;
    endtask

    // display side: random stalls, with occasional stall-free stretches
    initial begin
        int gap;
        do @(posedge i_clk); while (i_rst_n !== 1'b1);
        forever begin
            if ($urandom_range(0, 31) == 0) rx_gapless = !rx_gapless;
            gap = rx_gapless ? 0 : $urandom_range(0, 4);
            repeat (gap) begin
                i_ready <= 1'b0;
                @(posedge i_clk);
            end
            i_ready <= 1'b1;
            do @(posedge i_clk); while (!o_valid);
        end
    end

    always @(posedge i_clk) begin : check_display
        t_disp want;
        if (i_rst_n && o_valid && i_ready) begin
            if (pending_displays.size() == 0) begin
                report_mismatch($sformatf("unexpected display transaction mv=%0d",
                                          o_millivolts));
            end else begin
                want = pending_displays.pop_front();
                if (o_upper_word !== want.upper)
                    report_mismatch($sformatf("upper_word got %h want %h",
                                              o_upper_word, want.upper));
                if (o_lower_word !== want.lower)
                    report_mismatch($sformatf("lower_word got %h want %h",
                                              o_lower_word, want.lower));
                if (o_millivolts !== want.mv)
                    report_mismatch($sformatf("millivolts got %0d want %0d",
                                              o_millivolts, want.mv));
            end
        end
    end

    initial begin
        logic [adcvm_pkg::CNT_W-1:0]       spu;
        logic [adcvm_pkg::FS_W-1:0]        fs;
        logic [adcvm_pkg::SAMPLE_BITS-1:0] smp;
        int                                n;
        int                                phase;

        i_rst_n      <= 1'b0;
        i_valid      <= 1'b0;
        i_adc_sample <= '0;
        i_ready      <= 1'b0;
        psel         <= 1'b0;
        penable      <= 1'b0;
        pwrite       <= 1'b0;
        paddr        <= '0;
        pwdata       <= '0;
        avg_q        = '0;
        count_q      = '0;
        spu_q        = adcvm_pkg::SPU_RESET;
        fs_q         = adcvm_pkg::FS_RESET;

        // reset interval is 100: these five produce nothing
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd0,     0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd4095,  0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd2048,  0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd1,     0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd4095,  0, '0));
        // interval dropped below the count: next sample fires
        plan.push_back(mk_row(ROW_WRITE, adcvm_pkg::REG_SAMPLES_PER_UPDATE, 32'd3, 0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd1365,  0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd2730,  0, '0));
        // zero interval behaves as one; zero full scale reads 0.000
        plan.push_back(mk_row(ROW_WRITE, adcvm_pkg::REG_SAMPLES_PER_UPDATE, 32'd0, 0, '0));
        plan.push_back(mk_row(ROW_WRITE, adcvm_pkg::REG_FULL_SCALE_MV, 32'd0, 0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd4095,  1, DISP_ZERO));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd0,     1, DISP_ZERO));
        // oversized full scale saturates at 9.999
        plan.push_back(mk_row(ROW_WRITE, adcvm_pkg::REG_FULL_SCALE_MV, 32'h3FFF, 0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd4095,  0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd4095,  1, DISP_SAT));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd4095,  1, DISP_SAT));
        plan.push_back(mk_row(ROW_WRITE, adcvm_pkg::REG_FULL_SCALE_MV, 32'd9999, 0, '0));
        plan.push_back(mk_row(ROW_WRITE, adcvm_pkg::REG_SAMPLES_PER_UPDATE, 32'd1, 0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd4095,  0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd0,     0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'hAAA,   0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'h555,   0, '0));
        // unit full scale always truncates to zero
        plan.push_back(mk_row(ROW_WRITE, adcvm_pkg::REG_FULL_SCALE_MV, 32'd1, 0, '0));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd4095,  1, DISP_ZERO));
        plan.push_back(mk_row(ROW_SAMPLE, 1'b0, 32'd2048,  1, DISP_ZERO));

        repeat (RESET_CYCLES) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        foreach (plan[i]) begin
            if (plan[i].kind == ROW_WRITE) begin
                write_reg(plan[i].reg_idx, plan[i].value);
            end else begin
                send_sample(plan[i].value[adcvm_pkg::SAMPLE_BITS-1:0], plan[i].typed,
                            plan[i].want);
            end
        end

        phase = 0;
        while (items_sent < SAMPLE_ITEMS) begin
            case (phase)
                0: begin
                    spu = 7'd127;
                    fs  = 14'd9999;
                end
                1: begin
                    spu = 7'd1;
                    fs  = 14'h3FFF;
                end
                2: begin
                    spu = 7'd0;
                    fs  = adcvm_pkg::FS_W'($urandom_range(0, 9999));
                end
                default: begin
                    case ($urandom_range(0, 9))
                        0:       spu = 7'd0;
                        1:       spu = 7'd127;
                        2, 3:    spu = adcvm_pkg::CNT_W'($urandom_range(1, 127));
                        default: spu = adcvm_pkg::CNT_W'($urandom_range(1, 8));
                    endcase
                    case ($urandom_range(0, 7))
                        0:       fs = 14'd0;
                        1:       fs = 14'd9999;
                        2:       fs = adcvm_pkg::FS_W'($urandom_range(0, 16383));
                        default: fs = adcvm_pkg::FS_W'($urandom_range(1, 9999));
                    endcase
                end
            endcase
            // junk in the unused upper data bits must be dropped
            write_reg(adcvm_pkg::REG_SAMPLES_PER_UPDATE, ($urandom() & ~32'h7F) | 32'(spu));
            write_reg(adcvm_pkg::REG_FULL_SCALE_MV, ($urandom() & ~32'h3FFF) | 32'(fs));
            n = (spu > 16) ? 2 * spu + $urandom_range(0, spu) : $urandom_range(20, 80);
            tx_gapless = ($urandom_range(0, 3) == 0);
            for (int k = 0; k < n; k++) begin
                if (phase == 3 && k == n / 2) drain_outputs();
                case ($urandom_range(0, 7))
                    0:       smp = '0;
                    1:       smp = '1;
                    2:       smp = adcvm_pkg::SAMPLE_BITS'($urandom_range(4000, 4095));
                    default: smp = adcvm_pkg::SAMPLE_BITS'($urandom_range(0, 4095));
                endcase
                send_sample(smp, 0, '0);
            end
            phase++;
        end

        drain_outputs();
        if (mismatches == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
